// ===== rtl/mhfp_pkg.sv =====
// Shared types and constants of the mail header field parser.
// Used by the interfaces, the step logic, the result queue and the top level.
package mhfp_pkg;

  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_X     = 8'h58;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5a;
  localparam logic [7:0] CASE_OFS = 8'h20;

  localparam logic [7:0] FTEXT_LO   = 8'd33;
  localparam logic [7:0] FTEXT_GAP0 = 8'd57;
  localparam logic [7:0] FTEXT_GAP1 = 8'd59;
  localparam logic [7:0] FTEXT_HI   = 8'd126;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = QPTR_W + 1;

  typedef enum logic [2:0] {
    K_COPY       = 3'd0,
    K_NAME       = 3'd1,
    K_BODY       = 3'd2,
    K_FIELD_DONE = 3'd3,
    K_HDR_END    = 3'd4,
    K_ERROR      = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    E_NONE       = 2'd0,
    E_BAD_HEADER = 2'd1,
    E_8BIT       = 2'd2,
    E_DOT_LINE   = 2'd3
  } err_e;

  typedef enum logic [9:0] {
    ST_NAME_START  = 10'b00_0000_0001,
    ST_DOT_PENDING = 10'b00_0000_0010,
    ST_NAME        = 10'b00_0000_0100,
    ST_AFTER_NAME  = 10'b00_0000_1000,
    ST_DOTS        = 10'b00_0001_0000,
    ST_BODY_START  = 10'b00_0010_0000,
    ST_BODY        = 10'b00_0100_0000,
    ST_AFTER_CR    = 10'b00_1000_0000,
    ST_AFTER_NL    = 10'b01_0000_0000,
    ST_HALTED      = 10'b10_0000_0000
  } state_e;

  typedef struct packed {
    logic       new_message;
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_word_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [7:0] stored_byte;
    err_e       error_code;
  } res_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic [7:0] stored_byte;
    err_e       error_code;
    logic       last;
  } out_word_t;

  typedef struct packed {
    logic [1:0] n;
    res_t       r0;
    res_t       r1;
    state_e     st;
  } step_t;

endpackage

// ===== rtl/mhfp_if.sv =====
// Handshake channels of the mail header field parser: input, result and config.
// Depends on mhfp_pkg for the result codes.
interface mhfp_in_if;
  logic       valid;
  logic       ready;
  logic       new_message;
  logic [7:0] data_byte;
  logic       end_of_input;
  modport source (output valid, new_message, data_byte, end_of_input, input ready);
  modport sink   (input valid, new_message, data_byte, end_of_input, output ready);
endinterface

interface mhfp_out_if;
  logic                valid;
  logic                ready;
  mhfp_pkg::kind_e     kind;
  logic [7:0]          out_byte;
  logic [7:0]          stored_byte;
  mhfp_pkg::err_e      error_code;
  logic                last;
  modport source (output valid, kind, out_byte, stored_byte, error_code, last, input ready);
  modport sink   (input valid, kind, out_byte, stored_byte, error_code, last, output ready);
endinterface

interface mhfp_cfg_if;
  logic valid;
  logic ready;
  logic reject_8bit;
  modport source (output valid, reject_8bit, input ready);
  modport sink   (input valid, reject_8bit, output ready);
endinterface

// ===== rtl/mhfp_step.sv =====
// Per-byte parse logic: next state and up to two results for one input word.
// Depends on mhfp_pkg.
module mhfp_step (
  input  mhfp_pkg::state_e   state_i,
  input  mhfp_pkg::in_word_t word_i,
  input  logic               reject_8bit_i,
  output mhfp_pkg::step_t    step_o
);

  function automatic mhfp_pkg::res_t mk(mhfp_pkg::kind_e k, logic [7:0] ob, logic [7:0] sb,
                                         mhfp_pkg::err_e e);
    mhfp_pkg::res_t r;
    r.kind        = k;
    r.out_byte    = ob;
    r.stored_byte = sb;
    r.error_code  = e;
    return r;
  endfunction

  function automatic logic is_ftext(logic [7:0] c);
    return ((c >= mhfp_pkg::FTEXT_LO) && (c <= mhfp_pkg::FTEXT_GAP0)) ||
           ((c >= mhfp_pkg::FTEXT_GAP1) && (c <= mhfp_pkg::FTEXT_HI));
  endfunction

  function automatic logic is_ws(logic [7:0] c);
    return (c == mhfp_pkg::CH_SP) || (c == mhfp_pkg::CH_TAB);
  endfunction

  function automatic logic is_eol(logic [7:0] c);
    return (c == mhfp_pkg::CH_CR) || (c == mhfp_pkg::CH_LF);
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return ((c >= mhfp_pkg::CH_UC_A) && (c <= mhfp_pkg::CH_UC_Z)) ? c + mhfp_pkg::CASE_OFS : c;
  endfunction

  function automatic mhfp_pkg::step_t open_name(logic [7:0] c);
    mhfp_pkg::step_t t;
    t = '0;
    priority if (c == mhfp_pkg::CH_DOT) begin
      t.st = mhfp_pkg::ST_DOT_PENDING;
    end else if (is_eol(c)) begin
      t.n  = 2'd1;
      t.r0 = mk(mhfp_pkg::K_HDR_END, 8'h00, 8'h00, mhfp_pkg::E_NONE);
      t.st = mhfp_pkg::ST_HALTED;
    end else if (!is_ftext(c)) begin
      t.n  = 2'd1;
      t.r0 = mk(mhfp_pkg::K_ERROR, 8'h00, 8'h00, mhfp_pkg::E_BAD_HEADER);
      t.st = mhfp_pkg::ST_HALTED;
    end else begin
      t.n  = 2'd1;
      t.r0 = mk(mhfp_pkg::K_NAME, c, to_lower(c), mhfp_pkg::E_NONE);
      t.st = mhfp_pkg::ST_NAME;
    end
    return t;
  endfunction

  function automatic mhfp_pkg::step_t name_char(logic [7:0] c);
    mhfp_pkg::step_t t;
    t    = '0;
    t.n  = 2'd1;
    priority if (is_ws(c)) begin
      t.r0 = mk(mhfp_pkg::K_COPY, c, 8'h00, mhfp_pkg::E_NONE);
      t.st = mhfp_pkg::ST_AFTER_NAME;
    end else if (c == mhfp_pkg::CH_COLON) begin
      t.r0 = mk(mhfp_pkg::K_COPY, c, 8'h00, mhfp_pkg::E_NONE);
      t.st = mhfp_pkg::ST_BODY_START;
    end else if (!is_ftext(c)) begin
      t.r0 = mk(mhfp_pkg::K_ERROR, 8'h00, 8'h00, mhfp_pkg::E_BAD_HEADER);
      t.st = mhfp_pkg::ST_HALTED;
    end else begin
      t.r0 = mk(mhfp_pkg::K_NAME, c, to_lower(c), mhfp_pkg::E_NONE);
      t.st = mhfp_pkg::ST_NAME;
    end
    return t;
  endfunction

  function automatic mhfp_pkg::step_t body(logic [7:0] c, logic rej);
    mhfp_pkg::step_t t;
    t    = '0;
    t.n  = 2'd1;
    priority if (is_eol(c)) begin
      t.n  = 2'd2;
      t.r0 = mk(mhfp_pkg::K_COPY, mhfp_pkg::CH_CR, 8'h00, mhfp_pkg::E_NONE);
      t.r1 = mk(mhfp_pkg::K_COPY, mhfp_pkg::CH_LF, 8'h00, mhfp_pkg::E_NONE);
      t.st = (c == mhfp_pkg::CH_CR) ? mhfp_pkg::ST_AFTER_CR : mhfp_pkg::ST_AFTER_NL;
    end else if (c[7] && rej) begin
      t.r0 = mk(mhfp_pkg::K_ERROR, 8'h00, 8'h00, mhfp_pkg::E_8BIT);
      t.st = mhfp_pkg::ST_HALTED;
    end else if (c[7]) begin
      t.r0 = mk(mhfp_pkg::K_BODY, mhfp_pkg::CH_X, mhfp_pkg::CH_X, mhfp_pkg::E_NONE);
      t.st = mhfp_pkg::ST_BODY;
    end else begin
      t.r0 = mk(mhfp_pkg::K_BODY, c, c, mhfp_pkg::E_NONE);
      t.st = mhfp_pkg::ST_BODY;
    end
    return t;
  endfunction

  function automatic mhfp_pkg::step_t line_start(logic [7:0] c);
    mhfp_pkg::step_t t;
    mhfp_pkg::step_t s;
    t = '0;
    s = open_name(c);
    if (is_ws(c)) begin
      t.n  = 2'd1;
      t.r0 = mk(mhfp_pkg::K_COPY, c, 8'h00, mhfp_pkg::E_NONE);
      t.st = mhfp_pkg::ST_BODY;
    end else begin
      t.n  = 2'd1 + s.n;
      t.r0 = mk(mhfp_pkg::K_FIELD_DONE, 8'h00, 8'h00, mhfp_pkg::E_NONE);
      t.r1 = s.r0;
      t.st = s.st;
    end
    return t;
  endfunction

  mhfp_pkg::state_e eff_state;
  logic [7:0]       c;
  mhfp_pkg::step_t  nc;

  assign eff_state = word_i.new_message ? mhfp_pkg::ST_NAME_START : state_i;
  assign c         = word_i.data_byte;

  always_comb begin
    step_o = '0;
    nc     = name_char(c);
    if (word_i.end_of_input) begin
      step_o.st = mhfp_pkg::ST_HALTED;
      unique case (eff_state)
        mhfp_pkg::ST_HALTED: begin
          step_o.n = 2'd0;
        end
        mhfp_pkg::ST_DOT_PENDING: begin
          step_o.n  = 2'd2;
          step_o.r0 = mk(mhfp_pkg::K_NAME, mhfp_pkg::CH_DOT, mhfp_pkg::CH_DOT,
                         mhfp_pkg::E_NONE);
          step_o.r1 = mk(mhfp_pkg::K_HDR_END, 8'h00, 8'h00, mhfp_pkg::E_NONE);
        end
        mhfp_pkg::ST_DOTS: begin
          step_o.n  = 2'd1;
          step_o.r0 = mk(mhfp_pkg::K_ERROR, 8'h00, 8'h00, mhfp_pkg::E_BAD_HEADER);
        end
        mhfp_pkg::ST_AFTER_CR, mhfp_pkg::ST_AFTER_NL: begin
          step_o.n  = 2'd2;
          step_o.r0 = mk(mhfp_pkg::K_FIELD_DONE, 8'h00, 8'h00, mhfp_pkg::E_NONE);
          step_o.r1 = mk(mhfp_pkg::K_HDR_END, 8'h00, 8'h00, mhfp_pkg::E_NONE);
        end
        default: begin
          step_o.n  = 2'd1;
          step_o.r0 = mk(mhfp_pkg::K_HDR_END, 8'h00, 8'h00, mhfp_pkg::E_NONE);
        end
      endcase
    end else begin
      unique case (eff_state)
        mhfp_pkg::ST_NAME_START: step_o = open_name(c);
        mhfp_pkg::ST_DOT_PENDING: begin
          if (is_eol(c)) begin
            step_o.n  = 2'd1;
            step_o.r0 = mk(mhfp_pkg::K_ERROR, 8'h00, 8'h00, mhfp_pkg::E_DOT_LINE);
            step_o.st = mhfp_pkg::ST_HALTED;
          end else begin
            step_o.n  = 2'd2;
            step_o.r0 = mk(mhfp_pkg::K_NAME, mhfp_pkg::CH_DOT, mhfp_pkg::CH_DOT,
                           mhfp_pkg::E_NONE);
            step_o.r1 = nc.r0;
            step_o.st = nc.st;
          end
        end
        mhfp_pkg::ST_NAME: step_o = nc;
        mhfp_pkg::ST_AFTER_NAME: begin
          step_o.n  = 2'd1;
          step_o.r0 = mk(mhfp_pkg::K_COPY, c, 8'h00, mhfp_pkg::E_NONE);
          priority if (c == mhfp_pkg::CH_COLON) begin
            step_o.st = mhfp_pkg::ST_BODY_START;
          end else if (is_ws(c)) begin
            step_o.st = mhfp_pkg::ST_AFTER_NAME;
          end else if (c == mhfp_pkg::CH_DOT) begin
            step_o.st = mhfp_pkg::ST_DOTS;
          end else begin
            step_o.r0 = mk(mhfp_pkg::K_ERROR, 8'h00, 8'h00, mhfp_pkg::E_BAD_HEADER);
            step_o.st = mhfp_pkg::ST_HALTED;
          end
        end
        mhfp_pkg::ST_DOTS: begin
          step_o.n = 2'd1;
          if (c == mhfp_pkg::CH_DOT) begin
            step_o.r0 = mk(mhfp_pkg::K_COPY, c, 8'h00, mhfp_pkg::E_NONE);
            step_o.st = mhfp_pkg::ST_DOTS;
          end else begin
            step_o.r0 = mk(mhfp_pkg::K_ERROR, 8'h00, 8'h00, mhfp_pkg::E_BAD_HEADER);
            step_o.st = mhfp_pkg::ST_HALTED;
          end
        end
        mhfp_pkg::ST_BODY_START: begin
          if (is_ws(c)) begin
            step_o.n  = 2'd1;
            step_o.r0 = mk(mhfp_pkg::K_COPY, c, 8'h00, mhfp_pkg::E_NONE);
            step_o.st = mhfp_pkg::ST_BODY_START;
          end else begin
            step_o = body(c, reject_8bit_i);
          end
        end
        mhfp_pkg::ST_BODY: step_o = body(c, reject_8bit_i);
        mhfp_pkg::ST_AFTER_CR: begin
          if (c == mhfp_pkg::CH_LF) begin
            step_o.st = mhfp_pkg::ST_AFTER_NL;
          end else begin
            step_o = line_start(c);
          end
        end
        mhfp_pkg::ST_AFTER_NL: step_o = line_start(c);
        mhfp_pkg::ST_HALTED: step_o.st = mhfp_pkg::ST_HALTED;
        default: step_o.st = mhfp_pkg::ST_HALTED;
      endcase
    end
  end

endmodule

// ===== rtl/mhfp_res_fifo.sv =====
// Result queue: takes up to two result words a cycle, hands out one.
// Depends on mhfp_pkg for the word type and depth.
module mhfp_res_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [1:0]          push_n_i,
  input  mhfp_pkg::out_word_t push0_i,
  input  mhfp_pkg::out_word_t push1_i,
  output logic                room_o,
  output logic                valid_o,
  input  logic                pop_i,
  output mhfp_pkg::out_word_t word_o
);

  mhfp_pkg::out_word_t               mem_q [mhfp_pkg::QDEPTH];
  logic [mhfp_pkg::QPTR_W-1:0]       wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d, wr_ptr_nx;
  logic [mhfp_pkg::QCNT_W-1:0]       cnt_q, cnt_d;
  logic                              pop;

  assign valid_o   = (cnt_q != '0);
  assign pop       = pop_i & valid_o;
  assign word_o    = mem_q[rd_ptr_q];
  assign room_o    = (cnt_q <= mhfp_pkg::QCNT_W'(mhfp_pkg::QDEPTH - 2));
  assign wr_ptr_nx = wr_ptr_q + mhfp_pkg::QPTR_W'(1);

  always_comb begin
    wr_ptr_d = wr_ptr_q + mhfp_pkg::QPTR_W'(push_n_i);
    rd_ptr_d = rd_ptr_q + mhfp_pkg::QPTR_W'(pop);
    cnt_d    = cnt_q + mhfp_pkg::QCNT_W'(push_n_i) - mhfp_pkg::QCNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n_i != 2'd0) begin
      mem_q[wr_ptr_q] <= push0_i;
    end
    if (push_n_i == 2'd2) begin
      mem_q[wr_ptr_nx] <= push1_i;
    end
  end

endmodule

// ===== rtl/mail_header_field_parser_unit.sv =====
// Top level of the mail header field parser: state register, config register,
// per-byte step logic and result queue. Depends on mhfp_pkg, mhfp_if, mhfp_step, mhfp_res_fifo.
//
//   channel  dir  word                                          taken when
//   in_i     in   new_message, data_byte, end_of_input          valid & ready
//   out_o    out  kind, out_byte, stored_byte, error_code, last valid & ready
//   cfg_i    in   reject_8bit                                   valid & ready (ready always 1)
//
// One input byte per cycle while in_i.ready is high; its results enter a four-word queue
// at the accepting edge and show on out_o in order once the words ahead are taken.
// A byte with two results puts two words on out_o, with last set only on the second.
// in_i.ready drops while fewer than two queue slots are free.
// Reset: parser at name start, reject_8bit at 0, queue empty.
module mail_header_field_parser_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  mhfp_in_if.sink     in_i,
  mhfp_out_if.source  out_o,
  mhfp_cfg_if.sink    cfg_i
);

  mhfp_pkg::state_e    state_q, state_d;
  logic                reject_8bit_q, reject_8bit_d;
  mhfp_pkg::in_word_t  word;
  mhfp_pkg::step_t     step;
  mhfp_pkg::out_word_t push0, push1, head;
  logic [1:0]          push_n;
  logic                room, in_acc, q_valid;

  assign word.new_message  = in_i.new_message;
  assign word.data_byte    = in_i.data_byte;
  assign word.end_of_input = in_i.end_of_input;

  assign in_i.ready  = room;
  assign in_acc      = in_i.valid & room;
  assign cfg_i.ready = 1'b1;

  mhfp_step u_step (
    .state_i       (state_q),
    .word_i        (word),
    .reject_8bit_i (reject_8bit_q),
    .step_o        (step)
  );

  always_comb begin
    state_d       = in_acc ? step.st : state_q;
    reject_8bit_d = cfg_i.valid ? cfg_i.reject_8bit : reject_8bit_q;
    push_n        = in_acc ? step.n : 2'd0;
    push0         = {step.r0, (step.n == 2'd1)};
    push1         = {step.r1, 1'b1};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= mhfp_pkg::ST_NAME_START;
      reject_8bit_q <= 1'b0;
    end else begin
      state_q       <= state_d;
      reject_8bit_q <= reject_8bit_d;
    end
  end

  mhfp_res_fifo u_res_fifo (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_n_i (push_n),
    .push0_i  (push0),
    .push1_i  (push1),
    .room_o   (room),
    .valid_o  (q_valid),
    .pop_i    (out_o.ready),
    .word_o   (head)
  );

  assign out_o.valid       = q_valid;
  assign out_o.kind        = head.kind;
  assign out_o.out_byte    = head.out_byte;
  assign out_o.stored_byte = head.stored_byte;
  assign out_o.error_code  = head.error_code;
  assign out_o.last        = head.last;

endmodule

// ===== rtl/mhfp_checker.sv =====
// Port-level checks of the mail header field parser, bound to the top level.
// Depends on mhfp_pkg for the result codes.
module mhfp_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] kind_i,
  input logic [7:0] out_byte_i,
  input logic [7:0] stored_byte_i,
  input logic [1:0] error_code_i,
  input logic       last_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(kind_i) && $stable(out_byte_i)
      && $stable(last_i))
    else $error("result word changed while stalled");

  a_err_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> ((kind_i == mhfp_pkg::K_ERROR) == (error_code_i != mhfp_pkg::E_NONE)))
    else $error("error code does not match kind");

  a_no_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == mhfp_pkg::K_FIELD_DONE || kind_i == mhfp_pkg::K_HDR_END ||
      kind_i == mhfp_pkg::K_ERROR) |-> (out_byte_i == 8'h00) && (stored_byte_i == 8'h00))
    else $error("status word carries bytes");

  a_lower: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (kind_i == mhfp_pkg::K_NAME) |->
      !((stored_byte_i >= mhfp_pkg::CH_UC_A) && (stored_byte_i <= mhfp_pkg::CH_UC_Z)))
    else $error("name byte not lowercased");

endmodule

bind mail_header_field_parser_unit mhfp_checker u_mhfp_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .kind_i        (out_o.kind),
  .out_byte_i    (out_o.out_byte),
  .stored_byte_i (out_o.stored_byte),
  .error_code_i  (out_o.error_code),
  .last_i        (out_o.last)
);

// ===== tb/mhfp_tb_checker.sv =====
// Result checker for the mail header field parser: watches the input, result and
// config channels, predicts the tagged words of every accepted byte and compares them.
// Depends on mhfp_pkg and the channel interfaces of mhfp_if.
module mhfp_tb_checker
  import mhfp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  mhfp_in_if   in_mon,
  mhfp_out_if  out_mon,
  mhfp_cfg_if  cfg_mon,
  output int   mismatches_o,
  output int   waiting_o,
  output int   words_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_LF    = 8'h0a;
  localparam logic [7:0] C_CR    = 8'h0d;
  localparam logic [7:0] C_SP    = 8'h20;
  localparam logic [7:0] C_DOT   = 8'h2e;
  localparam logic [7:0] C_COLON = 8'h3a;
  localparam logic [7:0] C_X     = 8'h58;
  localparam logic [7:0] C_UC_A  = 8'h41;
  localparam logic [7:0] C_UC_Z  = 8'h5a;

  state_e    st   = ST_NAME_START;
  bit        rej8 = 1'b0;
  out_word_t byte_words[$];
  out_word_t tagged_q[$];

  function automatic bit is_ws(logic [7:0] c);
    return c == C_SP || c == C_TAB;
  endfunction

  function automatic bit is_eol(logic [7:0] c);
    return c == C_CR || c == C_LF;
  endfunction

  function automatic bit is_ftext(logic [7:0] c);
    return (c >= 8'd33 && c <= 8'd57) || (c >= 8'd59 && c <= 8'd126);
  endfunction

  function automatic logic [7:0] lower_byte(logic [7:0] c);
    return (c >= C_UC_A && c <= C_UC_Z) ? c + 8'd32 : c;
  endfunction

  function automatic void emit(kind_e k, logic [7:0] ob, logic [7:0] sb, err_e e);
    out_word_t w;
    if (byte_words.size() >= 2) return;
    w.kind        = k;
    w.out_byte    = ob;
    w.stored_byte = sb;
    w.error_code  = e;
    w.last        = 1'b0;
    byte_words.push_back(w);
  endfunction

  function automatic void start_name(logic [7:0] c);
    if (c == C_DOT) begin
      st = ST_DOT_PENDING;
    end else if (is_eol(c)) begin
      emit(K_HDR_END, 8'h00, 8'h00, E_NONE);
      st = ST_HALTED;
    end else if (!is_ftext(c)) begin
      emit(K_ERROR, 8'h00, 8'h00, E_BAD_HEADER);
      st = ST_HALTED;
    end else begin
      emit(K_NAME, c, lower_byte(c), E_NONE);
      st = ST_NAME;
    end
  endfunction

  function automatic void take_name(logic [7:0] c);
    if (is_ws(c)) begin
      emit(K_COPY, c, 8'h00, E_NONE);
      st = ST_AFTER_NAME;
    end else if (c == C_COLON) begin
      emit(K_COPY, c, 8'h00, E_NONE);
      st = ST_BODY_START;
    end else if (!is_ftext(c)) begin
      emit(K_ERROR, 8'h00, 8'h00, E_BAD_HEADER);
      st = ST_HALTED;
    end else begin
      emit(K_NAME, c, lower_byte(c), E_NONE);
    end
  endfunction

  function automatic void take_body(logic [7:0] c);
    logic [7:0] b;
    b = c;
    if (is_eol(b)) begin
      emit(K_COPY, C_CR, 8'h00, E_NONE);
      emit(K_COPY, C_LF, 8'h00, E_NONE);
      st = (b == C_CR) ? ST_AFTER_CR : ST_AFTER_NL;
    end else if (b[7] && rej8) begin
      emit(K_ERROR, 8'h00, 8'h00, E_8BIT);
      st = ST_HALTED;
    end else begin
      if (b[7]) b = C_X;
      emit(K_BODY, b, b, E_NONE);
      st = ST_BODY;
    end
  endfunction

  function automatic void start_line(logic [7:0] c);
    if (is_ws(c)) begin
      emit(K_COPY, c, 8'h00, E_NONE);
      st = ST_BODY;
    end else begin
      emit(K_FIELD_DONE, 8'h00, 8'h00, E_NONE);
      st = ST_NAME_START;
      start_name(c);
    end
  endfunction

  function automatic void finish_input();
    case (st)
      ST_HALTED: ;
      ST_DOT_PENDING: begin
        emit(K_NAME, C_DOT, C_DOT, E_NONE);
        emit(K_HDR_END, 8'h00, 8'h00, E_NONE);
      end
      ST_DOTS: emit(K_ERROR, 8'h00, 8'h00, E_BAD_HEADER);
      ST_AFTER_CR, ST_AFTER_NL: begin
        emit(K_FIELD_DONE, 8'h00, 8'h00, E_NONE);
        emit(K_HDR_END, 8'h00, 8'h00, E_NONE);
      end
      default: emit(K_HDR_END, 8'h00, 8'h00, E_NONE);
    endcase
    st = ST_HALTED;
  endfunction

  function automatic void tag_word(in_word_t w);
    logic [7:0] c;
    c = w.data_byte;
    byte_words.delete();
    if (w.new_message) st = ST_NAME_START;
    if (w.end_of_input) begin
      finish_input();
    end else begin
      case (st)
        ST_NAME_START: start_name(c);
        ST_DOT_PENDING: begin
          if (is_eol(c)) begin
            emit(K_ERROR, 8'h00, 8'h00, E_DOT_LINE);
            st = ST_HALTED;
          end else begin
            emit(K_NAME, C_DOT, C_DOT, E_NONE);
            st = ST_NAME;
            take_name(c);
          end
        end
        ST_NAME: take_name(c);
        ST_AFTER_NAME: begin
          if (c == C_COLON) begin
            emit(K_COPY, c, 8'h00, E_NONE);
            st = ST_BODY_START;
          end else if (is_ws(c)) begin
            emit(K_COPY, c, 8'h00, E_NONE);
          end else if (c == C_DOT) begin
            emit(K_COPY, c, 8'h00, E_NONE);
            st = ST_DOTS;
          end else begin
            emit(K_ERROR, 8'h00, 8'h00, E_BAD_HEADER);
            st = ST_HALTED;
          end
        end
        ST_DOTS: begin
          if (c == C_DOT) begin
            emit(K_COPY, c, 8'h00, E_NONE);
          end else begin
            emit(K_ERROR, 8'h00, 8'h00, E_BAD_HEADER);
            st = ST_HALTED;
          end
        end
        ST_BODY_START: begin
          if (is_ws(c)) emit(K_COPY, c, 8'h00, E_NONE);
          else take_body(c);
        end
        ST_BODY: take_body(c);
        ST_AFTER_CR: begin
          if (c == C_LF) st = ST_AFTER_NL;
          else start_line(c);
        end
        ST_AFTER_NL: start_line(c);
        default: st = ST_HALTED;
      endcase
    end
    if (byte_words.size() != 0) byte_words[byte_words.size() - 1].last = 1'b1;
    foreach (byte_words[i]) tagged_q.push_back(byte_words[i]);
  endfunction

  function automatic void compare_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      mismatches_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    in_word_t  iw;
    out_word_t want;
    out_word_t got;
    if (!rst_ni) begin
      st   = ST_NAME_START;
      rej8 = 1'b0;
      tagged_q.delete();
      mismatches_o = 0;
      waiting_o    = 0;
      words_seen_o = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        got.kind        = out_mon.kind;
        got.out_byte    = out_mon.out_byte;
        got.stored_byte = out_mon.stored_byte;
        got.error_code  = out_mon.error_code;
        got.last        = out_mon.last;
        words_seen_o++;
        if (tagged_q.size() == 0) begin
          $error("result word with none expected: kind %0d out_byte %0h",
                 got.kind, got.out_byte);
          mismatches_o++;
        end else begin
          want = tagged_q.pop_front();
          compare_field("kind", 8'(want.kind), 8'(got.kind));
          compare_field("out_byte", want.out_byte, got.out_byte);
          compare_field("stored_byte", want.stored_byte, got.stored_byte);
          compare_field("error_code", 8'(want.error_code), 8'(got.error_code));
          compare_field("last", 8'(want.last), 8'(got.last));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        iw.new_message  = in_mon.new_message;
        iw.data_byte    = in_mon.data_byte;
        iw.end_of_input = in_mon.end_of_input;
        tag_word(iw);
      end
      if (cfg_mon.valid && cfg_mon.ready) rej8 = cfg_mon.reject_8bit;
      waiting_o = tagged_q.size();
    end
  end

endmodule

// ===== tb/mail_header_field_parser_unit_tb.sv =====
// Testbench top of the mail header field parser: clock, reset, byte stimulus,
// result-side stalls and the verdict. Depends on mhfp_if, the block and mhfp_tb_checker.
module mail_header_field_parser_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_TARGET  = 1050;
  localparam int DRAIN_CYCLES = 8;
  localparam int HOLD_CYCLES  = 40;

  localparam logic [7:0] C_TAB   = 8'h09;
  localparam logic [7:0] C_LF    = 8'h0a;
  localparam logic [7:0] C_CR    = 8'h0d;
  localparam logic [7:0] C_SP    = 8'h20;
  localparam logic [7:0] C_DOT   = 8'h2e;
  localparam logic [7:0] C_COLON = 8'h3a;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  always #5 clk_i = ~clk_i;

  mhfp_in_if  in_ch ();
  mhfp_out_if out_ch ();
  mhfp_cfg_if cfg_ch ();

  int mismatches;
  int waiting;
  int words_seen;
  int words_sent = 0;
  int cfg_writes = 0;
  bit steady     = 1'b0;
  bit msg_start  = 1'b0;

  mail_header_field_parser_unit i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch),
    .cfg_i  (cfg_ch)
  );

  mhfp_tb_checker i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_ch),
    .out_mon      (out_ch),
    .cfg_mon      (cfg_ch),
    .mismatches_o (mismatches),
    .waiting_o    (waiting),
    .words_seen_o (words_seen)
  );

  task automatic send_word(input logic nm, input logic [7:0] b, input logic eoi);
    int gap;
    gap = steady ? 0 : $urandom_range(0, 3);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_ch.valid        <= 1'b1;
    in_ch.new_message  <= nm;
    in_ch.data_byte    <= b;
    in_ch.end_of_input <= eoi;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    words_sent++;
  endtask

  task automatic put_byte(input logic [7:0] b);
    send_word(msg_start, b, 1'b0);
    msg_start = 1'b0;
  endtask

  task automatic put_end();
    send_word(msg_start, 8'($urandom_range(0, 255)), 1'b1);
    msg_start = 1'b0;
  endtask

  task automatic put_eol();
    case ($urandom_range(0, 2))
      0: begin
        put_byte(C_CR);
        put_byte(C_LF);
      end
      1: put_byte(C_LF);
      default: put_byte(C_CR);
    endcase
  endtask

  function automatic logic [7:0] pick_ws();
    return $urandom_range(0, 1) ? C_SP : C_TAB;
  endfunction

  function automatic logic [7:0] name_char();
    int r;
    logic [7:0] c;
    r = $urandom_range(0, 9);
    if (r < 4) return 8'h41 + 8'($urandom_range(0, 25));
    if (r < 8) return 8'h61 + 8'($urandom_range(0, 25));
    c = 8'($urandom_range(33, 126));
    if (c == C_COLON) c = 8'h2d;
    return c;
  endfunction

  function automatic logic [7:0] body_char();
    int r;
    r = $urandom_range(0, 19);
    if (r < 2) return 8'($urandom_range(128, 255));
    if (r < 3) return C_TAB;
    return 8'($urandom_range(32, 126));
  endfunction

  // drop the rest of the message once a broken field has been sent
  task automatic send_field(output bit broken);
    broken = 1'b0;
    if ($urandom_range(0, 7) == 0) put_byte(C_DOT);
    repeat ($urandom_range(1, 6)) put_byte(name_char());
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 2)) put_byte(pick_ws());
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 3)) put_byte(C_DOT);
        if ($urandom_range(0, 1)) put_byte(8'($urandom_range(0, 255)));
        else put_end();
        broken = 1'b1;
        return;
      end
    end
    if ($urandom_range(0, 11) == 0) begin
      put_byte(8'($urandom_range(0, 255)));
      broken = 1'b1;
      return;
    end
    put_byte(C_COLON);
    if ($urandom_range(0, 1)) put_byte(C_SP);
    repeat ($urandom_range(0, 10)) put_byte(body_char());
    put_eol();
    if ($urandom_range(0, 3) == 0) begin
      put_byte(pick_ws());
      repeat ($urandom_range(0, 6)) put_byte(body_char());
      put_eol();
    end
  endtask

  task automatic send_message();
    bit broken;
    msg_start = 1'b1;
    repeat ($urandom_range(1, 3)) begin
      send_field(broken);
      if (broken) return;
    end
    case ($urandom_range(0, 5))
      0: begin
        put_byte(C_CR);
        put_byte(C_LF);
      end
      1: put_byte(C_LF);
      2: put_end();
      3: begin
        put_byte(C_DOT);
        put_byte(C_CR);
      end
      4: begin
        put_byte(C_DOT);
        put_end();
      end
      default: begin
        put_byte(name_char());
        put_end();
      end
    endcase
  endtask

  task automatic send_noise();
    repeat ($urandom_range(1, 8))
      send_word($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)),
                $urandom_range(0, 9) == 0);
  endtask

  task automatic wait_idle();
    in_ch.valid <= 1'b0;
    while (waiting != 0) @(negedge clk_i);
    repeat (DRAIN_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_reject(input logic v);
    wait_idle();
    cfg_ch.valid       <= 1'b1;
    cfg_ch.reject_8bit <= v;
    @(posedge clk_i);
    while (!cfg_ch.ready) @(posedge clk_i);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
    cfg_writes++;
  endtask

  initial begin
    int phase_end;
    in_ch.valid        = 1'b0;
    in_ch.new_message  = 1'b0;
    in_ch.data_byte    = 8'h00;
    in_ch.end_of_input = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.reject_8bit = 1'b0;
    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // whitespace and a dot run between name and colon
    msg_start = 1'b1;
    put_byte(8'h5a); put_byte(8'h7e); put_byte(C_SP); put_byte(C_TAB);
    put_byte(C_DOT); put_byte(C_DOT); put_byte(C_COLON);
    // 8-bit replacement, CR LF, folding, then a dot line
    msg_start = 1'b1;
    put_byte(8'h21); put_byte(8'h39); put_byte(C_COLON); put_byte(C_SP);
    put_byte(8'hff); put_byte(8'h80); put_byte(C_CR); put_byte(C_LF);
    put_byte(C_TAB); put_byte(8'h7e); put_byte(C_LF); put_byte(C_DOT); put_byte(C_CR);
    // held dot at end of input
    msg_start = 1'b1;
    put_byte(C_DOT); put_end();
    // end of input right after a line end
    msg_start = 1'b1;
    put_byte(8'h61); put_byte(C_COLON); put_byte(C_CR); put_end();

    for (int ph = 0; ph < 4; ph++) begin
      write_reject(ph[0] == 1'b0);
      steady    = (ph == 2);
      phase_end = words_sent + ITEM_TARGET / 4;
      while (words_sent < phase_end) begin
        if ($urandom_range(0, 99) < 12) send_noise();
        else send_message();
      end
    end

    wait_idle();
    $display("sent %0d input words, checked %0d result words, %0d register writes",
             words_sent, words_seen, cfg_writes);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // result side: random stalls per word, two long holds to back up the input
  initial begin
    int gap;
    int taken;
    out_ch.ready = 1'b0;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken == 150 || taken == 600) begin
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk_i);
      end
      gap = steady ? 0 : $urandom_range(0, 3);
      if (gap != 0) begin
        out_ch.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
      taken++;
      @(negedge clk_i);
    end
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d result words still expected", waiting);
    $display("== FAIL ==");
    $finish;
  end

endmodule
